/* rtl/ple_pkg.sv */
// shared types, codes and defaults for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DefaultDepth = 16;
    localparam int ValueW       = 32;

    typedef enum logic [2:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_DELETE   = 3'd3,
        ACT_SEARCH   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              cmp;
        logic [ValueW-1:0] value;
    } t_cell_ctrl;

endpackage

/* rtl/ple_cell.sv */
// one list slot: holds an element, shifts with its neighbours, compares for search
`timescale 1ns / 1ps

module ple_cell #(
    parameter int DEPTH = ple_pkg::DefaultDepth,
    parameter int IDX   = 0,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  ple_pkg::t_cell_ctrl         i_ctrl,
    input  logic [IW-1:0]               i_idx,
    input  logic [CW-1:0]               i_count,
    input  logic [ple_pkg::ValueW-1:0]  i_left,
    input  logic [ple_pkg::ValueW-1:0]  i_right,
    output logic [ple_pkg::ValueW-1:0]  o_data,
    output logic                        o_match
);

    localparam logic [IW-1:0] MyIdx = IW'(IDX);
    localparam logic [CW-1:0] MyCnt = CW'(IDX);

    logic [ple_pkg::ValueW-1:0] r_data;
    logic [ple_pkg::ValueW-1:0] n_data;
    logic                       r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (MyIdx == i_idx) begin
                n_data = i_ctrl.value;
            end else if (MyIdx > i_idx) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if (MyIdx >= i_idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        // only slots below the count take part in a search
        if (i_ctrl.cmp) begin
            r_match <= (MyCnt < i_count) && (r_data == i_ctrl.value);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

/* rtl/positional_list_engine.sv */
// top level: action decode, row of list cells, first-match encode and result register
`timescale 1ns / 1ps

// Bounded ordered list of DEPTH signed 32-bit values held in a row of cells; element 1 is
// the head. Each transfer carries one action (insert at head, tail or position, delete at
// position, search) and gives exactly one result: status, first matching position and the
// element count after the action. Cells shift and compare all at once, so a new action is
// taken every cycle while o_stall is low. The cells update and latch their compare bits
// at the input transfer, and when the held action advances a priority encoder over the
// compare bits loads the output register. A stall on the output holds one result in the
// output register and one behind it before the input is stalled.

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DefaultDepth,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_action,
    input  logic [CW-1:0]                      i_position,
    input  logic signed [ple_pkg::ValueW-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_status,
    output logic [CW-1:0]                      o_found_position,
    output logic [CW-1:0]                      o_element_count
);

    localparam logic [CW:0] DepthX = (CW + 1)'(DEPTH);

    logic                      in_xfer;
    logic                      s1_adv;
    ple_pkg::t_cell_ctrl       cell_ctrl;
    logic [IW-1:0]             cell_idx;
    logic [CW-1:0]             n_count;
    ple_pkg::t_status          dec_status;
    logic                      dec_search;
    logic [CW:0]               pos_x;
    logic [CW:0]               cnt_x;
    logic [CW:0]               ins_pos;

    logic [CW-1:0]             r_count;
    logic                      r_s1_valid;
    ple_pkg::t_status          r_s1_status;
    logic                      r_s1_search;
    logic [CW-1:0]             r_s1_count;
    logic                      r_o_valid;
    ple_pkg::t_status          r_o_status;
    logic [CW-1:0]             r_o_found;
    logic [CW-1:0]             r_o_count;

    logic [ple_pkg::ValueW-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]           match_vec;
    logic [CW-1:0]              first_pos;

    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_xfer = i_valid && !o_stall;

    // action decode against the current count
    always_comb begin
        cell_ctrl       = '0;
        cell_ctrl.value = i_value;
        cell_idx        = '0;
        n_count         = r_count;
        dec_status      = ple_pkg::ST_OK;
        dec_search      = 1'b0;
        pos_x           = {1'b0, i_position};
        cnt_x           = {1'b0, r_count};
        ins_pos         = pos_x;
        case (ple_pkg::t_action'(i_action)) inside
            ple_pkg::ACT_INS_HEAD, ple_pkg::ACT_INS_TAIL, ple_pkg::ACT_INS_POS: begin
                if (ple_pkg::t_action'(i_action) == ple_pkg::ACT_INS_HEAD) begin
                    ins_pos = (CW + 1)'(1);
                end else if (ple_pkg::t_action'(i_action) == ple_pkg::ACT_INS_TAIL) begin
                    ins_pos = cnt_x + (CW + 1)'(1);
                end
                if (ins_pos == '0 || ins_pos > cnt_x + (CW + 1)'(1)) begin
                    dec_status = ple_pkg::ST_RANGE;
                end else if (cnt_x == DepthX) begin
                    dec_status = ple_pkg::ST_FULL;
                end else begin
                    cell_ctrl.ins = 1'b1;
                    cell_idx      = IW'(ins_pos - (CW + 1)'(1));
                    n_count       = r_count + CW'(1);
                end
            end
            ple_pkg::ACT_DELETE: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                    dec_status = ple_pkg::ST_RANGE;
                end else begin
                    cell_ctrl.del = 1'b1;
                    cell_idx      = IW'(pos_x - (CW + 1)'(1));
                    n_count       = r_count - CW'(1);
                end
            end
            ple_pkg::ACT_SEARCH: begin
                if (r_count == '0) begin
                    dec_status = ple_pkg::ST_EMPTY;
                end else begin
                    cell_ctrl.cmp = 1'b1;
                    dec_search    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!in_xfer) begin
            cell_ctrl.ins = 1'b0;
            cell_ctrl.del = 1'b0;
            cell_ctrl.cmp = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ple_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl),
                .i_idx   (cell_idx),
                .i_count (r_count),
                .i_left  (cell_data[(g == 0) ? 0 : g - 1]),
                .i_right (cell_data[(g == DEPTH - 1) ? g : g + 1]),
                .o_data  (cell_data[g]),
                .o_match (match_vec[g])
            );
        end
    endgenerate

    // lowest matching slot wins
    always_comb begin
        first_pos = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match_vec[k]) begin
                first_pos = CW'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_status <= dec_status;
            r_s1_search <= dec_search;
            r_s1_count  <= n_count;
        end
        if (s1_adv) begin
            r_o_count <= r_s1_count;
            if (r_s1_search) begin
                r_o_status <= (first_pos != '0) ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
                r_o_found  <= first_pos;
            end else begin
                r_o_status <= r_s1_status;
                r_o_found  <= '0;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_element_count  = r_o_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= DepthX)
        else $error("element count beyond depth");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_count))
        else $error("count changed without an input transfer");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_found != '0) |->
            (r_o_status == ple_pkg::ST_OK && r_o_found <= r_o_count))
        else $error("found position without a good search result");
`endif

endmodule
